// ===== rtl/core/ins_pkg.sv =====
// ----------------------------------------------------------------------------
// ins_pkg: shared types and constants of the insertion sorter
// Holds the field widths, the default capacity and the command and status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ins_pkg;

  // Width of one sorted element
  localparam int VALUE_W = 32;

  // Default capacity of the sorted store
  localparam int DEPTH_DEFAULT = 64;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic insert;    // insert the incoming value into the store
    logic drop;      // store is full: drop the value and mark the set
    logic pop;       // move the lowest entry to the output register
  } ins_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic full;      // store holds DEPTH entries
    logic one_left;  // exactly one entry remains
    logic out_free;  // output register can take an item this cycle
  } ins_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/ins_stream_if.sv =====
// ----------------------------------------------------------------------------
// ins_stream_if: item channels of the insertion sorter
// Input channel carries one value and its closing flag, output channel
// carries one sorted element with its set flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ins_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ins_pkg::VALUE_W-1:0]   value;
  logic                                 last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface ins_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ins_pkg::VALUE_W-1:0]   sorted_value;
  logic                                 last_of_set;
  logic                                 overflowed;

  modport source (output valid, output sorted_value, output last_of_set,
                  output overflowed, input ready);
  modport sink   (input valid, input sorted_value, input last_of_set,
                  input overflowed, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ins_ctrl.sv =====
// ----------------------------------------------------------------------------
// ins_ctrl: sequencing of fill and drain
// Accepts items while filling, then pops the store one entry per free
// output slot until the set is emptied.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ins_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic                 in_last,
  output logic                      in_ready,
  input  wire ins_pkg::ins_status_t status,
  output ins_pkg::ins_cmd_t         cmd
);

  typedef enum logic [1:0] {
    ST_FILL  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == ST_FILL);
  assign accept   = in_valid && in_ready;

  // Decode commands and the next state
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_FILL: begin
        if (accept) begin
          cmd.insert = !status.full;
          cmd.drop   = status.full;
          if (in_last) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (status.out_free) begin
          cmd.pop = 1'b1;
          if (status.one_left) begin
            state_next = ST_FILL;
          end
        end
      end
      default: begin
        state_next = ST_FILL;
      end
    endcase
  end

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ins_datapath.sv =====
// ----------------------------------------------------------------------------
// ins_datapath: compare-and-shift cells and output register
// Each cell compares its entry with the key and shifts up on insert;
// on pop the row shifts down and the lowest entry goes to the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ins_datapath #(
  parameter int DEPTH = ins_pkg::DEPTH_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire ins_pkg::ins_cmd_t                 cmd,
  output ins_pkg::ins_status_t                   status,
  input  wire logic signed [ins_pkg::VALUE_W-1:0] key,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [ins_pkg::VALUE_W-1:0]     out_value,
  output logic                                   out_last,
  output logic                                   out_ovf
);

  localparam int CW = $clog2(DEPTH + 1);

  logic signed [ins_pkg::VALUE_W-1:0] store [DEPTH];
  logic [CW-1:0]                      count;
  logic                               overflow;
  logic [DEPTH-1:0]                   gt;

  // Compare every cell with the key; empty cells count as greater
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      gt[i] = (CW'(i) >= count) || (store[i] > key);
    end
  end

  assign status.full     = (count == CW'(DEPTH));
  assign status.one_left = (count == CW'(1));
  assign status.out_free = !out_valid || out_ready;

  // Shift the cells: up on insert, down on pop
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    always_ff @(posedge clk) begin
      if (cmd.insert && gt[i]) begin
        if (i == 0) begin
          store[i] <= key;
        end else begin
          store[i] <= gt[(i == 0) ? 0 : i - 1] ? store[(i == 0) ? 0 : i - 1] : key;
        end
      end else if (cmd.pop && (i < DEPTH - 1)) begin
        store[i] <= store[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  // Track fill count and the dropped-value mark
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
    end else begin
      if (cmd.insert) begin
        count <= count + CW'(1);
      end else if (cmd.pop) begin
        count <= count - CW'(1);
      end
      if (cmd.drop) begin
        overflow <= 1'b1;
      end else if (cmd.pop && status.one_left) begin
        overflow <= 1'b0;
      end
    end
  end

  // Load the output register on pop, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      out_value <= store[0];
      out_last  <= status.one_left;
      out_ovf   <= overflow || cmd.drop;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/insertion_sorter.sv =====
// Insertion sorter: one value is taken per cycle while a set is filling.
// After the closing item the results leave at one per cycle while the output
// is ready; the state register first turns to drain, then each pop loads the
// output register. Input is held off until the last entry has been popped.
// Reset (synchronous, rst high) empties the store and clears the output.
// ----------------------------------------------------------------------------
// insertion_sorter: top level of the streaming insertion sorter
// Joins the fill/drain controller with the compare-and-shift datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module insertion_sorter #(
  parameter int DEPTH = ins_pkg::DEPTH_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst,
  ins_in_if.sink     in_items,
  ins_out_if.source  out_items
);

  ins_pkg::ins_cmd_t    cmd;
  ins_pkg::ins_status_t status;

  ins_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_items.valid),
    .in_last  (in_items.last_item),
    .in_ready (in_items.ready),
    .status   (status),
    .cmd      (cmd)
  );

  ins_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .key       (in_items.value),
    .out_valid (out_items.valid),
    .out_ready (out_items.ready),
    .out_value (out_items.sorted_value),
    .out_last  (out_items.last_of_set),
    .out_ovf   (out_items.overflowed)
  );

endmodule

`default_nettype wire
